// ===== src/sscl_pkg.sv =====
// Package: sizes, state codes and post-file write bundle for the span clip list.
`default_nettype none

package sscl_pkg;

   localparam int MAX_POSTS   = 16;
   localparam int MAX_RESULTS = 16;
   localparam int IDX_W       = $clog2(MAX_POSTS);
   localparam int CNT_W       = $clog2(MAX_POSTS + 1);
   localparam int RES_W       = $clog2(MAX_RESULTS + 1);
   localparam int ANG_W       = 16;
   localparam int HALF_W      = 15;

   localparam logic [HALF_W-1:0] HALF_RESET = 15'd8192;
   localparam logic [ANG_W-1:0]  HALF_TURN  = 16'h8000;
   localparam logic [ANG_W-1:0]  ANGLE_MAX  = 16'hFFFF;

   localparam logic CMD_CLEAR  = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_SHIFT,
      ST_FUSE,
      ST_COMPACT,
      ST_FINISH
   } state_type;

   // One write per cycle into the post file, plus the two-entry sentinel rebuild.
   typedef struct packed {
      logic              up_en;
      logic              lo_en;
      logic [IDX_W-1:0]  idx;
      logic [ANG_W-1:0]  up;
      logic [ANG_W-1:0]  lo;
      logic              clr;
      logic [HALF_W-1:0] half;
   } post_wr_type;

   function automatic logic [ANG_W-1:0] sentinel_lo0(input logic [HALF_W-1:0] h);
      return HALF_TURN + {1'b0, h};
   endfunction

   function automatic logic [ANG_W-1:0] sentinel_up1(input logic [HALF_W-1:0] h);
      return HALF_TURN - {1'b0, h};
   endfunction

endpackage

`default_nettype wire

// ===== src/sscl_post_file.sv =====
// Post file: upper and lower angle of each occluded range, one read and one write port.
`default_nettype none

module sscl_post_file (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire sscl_pkg::post_wr_type    wr,
   input  wire logic [sscl_pkg::IDX_W-1:0] rd_idx,
   output logic [sscl_pkg::ANG_W-1:0]    rd_up,
   output logic [sscl_pkg::ANG_W-1:0]    rd_lo
);
   import sscl_pkg::*;

   logic [ANG_W-1:0] up_ff [MAX_POSTS];
   logic [ANG_W-1:0] lo_ff [MAX_POSTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff[0] <= ANGLE_MAX;
         lo_ff[0] <= sentinel_lo0(HALF_RESET);
         up_ff[1] <= sentinel_up1(HALF_RESET);
         lo_ff[1] <= '0;
      end else if (wr.clr) begin
         up_ff[0] <= ANGLE_MAX;
         lo_ff[0] <= sentinel_lo0(wr.half);
         up_ff[1] <= sentinel_up1(wr.half);
         lo_ff[1] <= '0;
      end else begin
         if (wr.up_en) begin
            up_ff[wr.idx] <= wr.up;
         end
         if (wr.lo_en) begin
            lo_ff[wr.idx] <= wr.lo;
         end
      end
   end

   assign rd_up = up_ff[rd_idx];
   assign rd_lo = lo_ff[rd_idx];

endmodule

`default_nettype wire

// ===== src/solid_span_clip_list.sv =====
// Top level: solid span clip list with a one-post-per-cycle sequencer, held while a fragment cannot be emitted.
//
//   channel  | ports                       | contents
//   ---------+-----------------------------+-----------------------------------------
//   request  | req_tvalid/tready/tdata/tuser | clear or insert one span
//   response | rsp_tvalid/tready/tdata/tuser/tlast | visible fragments, last marked
//   config   | csr_wr_en/csr_wr_data       | half field-of-view angle
//
// A clear is accepted and then finishes. An insert is accepted, scans past posts one at a
// time, checks the first post touched, fuses one fragment at a time, moves posts to open a
// slot or to close up the list, and finishes; the post file's single read port paces each
// of these steps.
// A fragment waits in a holding register until the next appears; stall while both it
// and the output register are full. Reset is synchronous and rebuilds the sentinels.
`default_nettype none

module solid_span_clip_list (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // span_top[15:0], span_bottom[31:16]
   input  wire logic [0:0]  req_tuser,   // cmd[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // fragment_start[15:0], fragment_stop[31:16]
   output logic [1:0]       rsp_tuser,   // fragment_valid[0], overflow[1]
   output logic             rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic [14:0] csr_wr_data
);
   import sscl_pkg::*;

   state_type        state_ff, state_in;
   logic [HALF_W-1:0] half_ff;
   logic [ANG_W-1:0] top_ff, top_in, bot_ff, bot_in;
   logic [IDX_W-1:0] s_ff, s_in, nx_ff, nx_in, rem_ff, rem_in;
   logic [CNT_W-1:0] i_ff, i_in, cnt_ff, cnt_in;
   logic [ANG_W-1:0] lo_nx_ff, lo_nx_in;
   logic [RES_W-1:0] res_cnt_ff, res_cnt_in;
   logic             ovf_ff, ovf_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [ANG_W-1:0] pend_a_ff, pend_a_in, pend_b_ff, pend_b_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [ANG_W-1:0] rsp_start_ff, rsp_start_in, rsp_stop_ff, rsp_stop_in;
   logic             rsp_fv_ff, rsp_fv_in, rsp_ovf_ff, rsp_ovf_in, rsp_last_ff, rsp_last_in;

   post_wr_type      wr;
   logic [IDX_W-1:0] rd_idx;
   logic [ANG_W-1:0] rd_up, rd_lo;

   logic             out_free, emit_req, emit_drop, emit_ok;
   logic [ANG_W-1:0] emit_a, emit_b;
   logic [CNT_W-1:0] s_ext, nx1;
   logic [ANG_W:0]   top_p1, up_p1, bot_w;

   sscl_post_file u_posts (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .rd_idx (rd_idx),
      .rd_up  (rd_up),
      .rd_lo  (rd_lo)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s_ext      = CNT_W'(s_ff);
   assign nx1        = CNT_W'(nx_ff) + CNT_W'(1);
   assign top_p1     = {1'b0, top_ff} + (ANG_W+1)'(1);
   assign up_p1      = {1'b0, rd_up} + (ANG_W+1)'(1);
   assign bot_w      = {1'b0, bot_ff};

   always_comb begin
      state_in      = state_ff;
      top_in        = top_ff;
      bot_in        = bot_ff;
      s_in          = s_ff;
      nx_in         = nx_ff;
      rem_in        = rem_ff;
      i_in          = i_ff;
      cnt_in        = cnt_ff;
      lo_nx_in      = lo_nx_ff;
      res_cnt_in    = res_cnt_ff;
      ovf_in        = ovf_ff;
      pend_valid_in = pend_valid_ff;
      pend_a_in     = pend_a_ff;
      pend_b_in     = pend_b_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_start_in  = rsp_start_ff;
      rsp_stop_in   = rsp_stop_ff;
      rsp_fv_in     = rsp_fv_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_last_in   = rsp_last_ff;
      wr            = '0;
      wr.half       = half_ff;
      rd_idx        = s_ff;
      emit_req      = 1'b0;
      emit_a        = '0;
      emit_b        = '0;
      emit_drop     = (res_cnt_ff >= RES_W'(MAX_RESULTS));
      // A fragment can always go into the holding register when it is empty.
      emit_ok       = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               top_in     = req_tdata[15:0];
               bot_in     = req_tdata[31:16];
               s_in       = '0;
               res_cnt_in = '0;
               ovf_in     = 1'b0;
               if (req_tuser[0] == CMD_CLEAR) begin
                  wr.clr   = 1'b1;
                  cnt_in   = CNT_W'(2);
                  state_in = ST_FINISH;
               end else begin
                  // rebuild the sentinels first when fusing has left a single post
                  if (cnt_ff < CNT_W'(2)) begin
                     wr.clr = 1'b1;
                     cnt_in = CNT_W'(2);
                  end
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if ((s_ext + CNT_W'(1) < cnt_ff) && ({1'b0, rd_lo} > top_p1)) begin
               s_in = s_ff + IDX_W'(1);
            end else begin
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            if (top_ff > rd_up) begin
               emit_req = 1'b1;
               emit_a   = top_ff;
               emit_ok  = emit_drop || !pend_valid_ff || out_free;
               if (bot_w > up_p1) begin
                  emit_b = bot_ff;
                  if (emit_ok) begin
                     if (cnt_ff >= CNT_W'(MAX_POSTS)) begin
                        ovf_in   = 1'b1;
                        state_in = ST_FINISH;
                     end else begin
                        i_in     = cnt_ff;
                        state_in = ST_SHIFT;
                     end
                  end
               end else begin
                  emit_b = up_p1[ANG_W-1:0];
                  if (emit_ok) begin
                     wr.up_en = 1'b1;
                     wr.idx   = s_ff;
                     wr.up    = top_ff;
                     lo_nx_in = rd_lo;
                     nx_in    = s_ff;
                     state_in = (bot_ff >= rd_lo) ? ST_FINISH : ST_FUSE;
                  end
               end
            end else begin
               lo_nx_in = rd_lo;
               nx_in    = s_ff;
               state_in = (bot_ff >= rd_lo) ? ST_FINISH : ST_FUSE;
            end
         end

         ST_SHIFT: begin
            // open a slot at s, moving one post down per cycle from the tail
            if (i_ff > s_ext) begin
               rd_idx   = IDX_W'(i_ff - CNT_W'(1));
               wr.up_en = 1'b1;
               wr.lo_en = 1'b1;
               wr.idx   = IDX_W'(i_ff);
               wr.up    = rd_up;
               wr.lo    = rd_lo;
               i_in     = i_ff - CNT_W'(1);
            end else begin
               wr.up_en = 1'b1;
               wr.lo_en = 1'b1;
               wr.idx   = s_ff;
               wr.up    = top_ff;
               wr.lo    = bot_ff;
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = ST_FINISH;
            end
         end

         ST_FUSE: begin
            rd_idx   = nx1[IDX_W-1:0];
            emit_req = 1'b1;
            emit_a   = lo_nx_ff - ANG_W'(1);
            emit_ok  = emit_drop || !pend_valid_ff || out_free;
            if (!(nx1 < cnt_ff) || (bot_w > up_p1)) begin
               emit_b = bot_ff;
               if (emit_ok) begin
                  wr.lo_en = 1'b1;
                  wr.idx   = s_ff;
                  wr.lo    = bot_ff;
                  if (nx_ff == s_ff) begin
                     state_in = ST_FINISH;
                  end else begin
                     rem_in   = nx_ff - s_ff;
                     i_in     = nx1;
                     state_in = ST_COMPACT;
                  end
               end
            end else begin
               emit_b = up_p1[ANG_W-1:0];
               if (emit_ok) begin
                  nx_in = nx1[IDX_W-1:0];
                  if (bot_ff >= rd_lo) begin
                     wr.lo_en = 1'b1;
                     wr.idx   = s_ff;
                     wr.lo    = rd_lo;
                     rem_in   = IDX_W'(nx1 - s_ext);
                     i_in     = nx1 + CNT_W'(1);
                     state_in = ST_COMPACT;
                  end else begin
                     lo_nx_in = rd_lo;
                  end
               end
            end
         end

         ST_COMPACT: begin
            // close the gap left by swallowed posts, one post per cycle
            if (i_ff < cnt_ff) begin
               rd_idx   = IDX_W'(i_ff);
               wr.up_en = 1'b1;
               wr.lo_en = 1'b1;
               wr.idx   = IDX_W'(i_ff - CNT_W'(rem_ff));
               wr.up    = rd_up;
               wr.lo    = rd_lo;
               i_in     = i_ff + CNT_W'(1);
            end else begin
               cnt_in   = cnt_ff - CNT_W'(rem_ff);
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_start_in  = pend_valid_ff ? pend_a_ff : '0;
               rsp_stop_in   = pend_valid_ff ? pend_b_ff : '0;
               rsp_fv_in     = pend_valid_ff;
               rsp_ovf_in    = ovf_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // push the held fragment out, hold the new one until the next is known
      if (emit_req && emit_ok && !emit_drop) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_start_in = pend_a_ff;
            rsp_stop_in  = pend_b_ff;
            rsp_fv_in    = 1'b1;
            rsp_ovf_in   = 1'b0;
            rsp_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_a_in     = emit_a;
         pend_b_in     = emit_b;
         res_cnt_in    = res_cnt_ff + RES_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         half_ff       <= HALF_RESET;
         cnt_ff        <= CNT_W'(2);
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         res_cnt_ff    <= '0;
         ovf_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_wr_en) begin
            half_ff <= csr_wr_data;
         end
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         res_cnt_ff    <= res_cnt_in;
         ovf_ff        <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff       <= top_in;
      bot_ff       <= bot_in;
      s_ff         <= s_in;
      nx_ff        <= nx_in;
      rem_ff       <= rem_in;
      i_ff         <= i_in;
      lo_nx_ff     <= lo_nx_in;
      pend_a_ff    <= pend_a_in;
      pend_b_ff    <= pend_b_in;
      rsp_start_ff <= rsp_start_in;
      rsp_stop_ff  <= rsp_stop_in;
      rsp_fv_ff    <= rsp_fv_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_stop_ff, rsp_start_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_fv_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== tb/solid_span_clip_list_test.sv =====
// Self-checking bench for the span clip list: random spans, clears and half-angle changes.
`timescale 1ns / 1ps

module solid_span_clip_list_test;
   import sscl_pkg::*;

   localparam int SETTLE_CYCLES = 2 * MAX_POSTS + 12;

   typedef struct packed {
      logic             cmd;
      logic [ANG_W-1:0] top;
      logic [ANG_W-1:0] bottom;
   } span_item_type;

   typedef struct packed {
      logic [ANG_W-1:0] start;
      logic [ANG_W-1:0] stop;
      logic             vld;
      logic             ovf;
      logic             last;
   } fragment_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata   = '0;   // span_top[15:0], span_bottom[31:16]
   logic [0:0]        req_tuser   = '0;   // cmd[0]
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [31:0]       rsp_tdata;          // fragment_start[15:0], fragment_stop[31:16]
   logic [1:0]        rsp_tuser;          // fragment_valid[0], overflow[1]
   logic              rsp_tlast;
   logic              csr_wr_en   = 1'b0;
   logic [HALF_W-1:0] csr_wr_data = '0;

   // span list mirror
   logic [ANG_W-1:0]  occ_upper [0:MAX_POSTS-1];
   logic [ANG_W-1:0]  occ_lower [0:MAX_POSTS-1];
   int unsigned       occ_count;
   logic [HALF_W-1:0] half_angle;

   span_item_type span_queue[$];
   fragment_type  fragments_due[$];
   fragment_type  new_fragments[$];
   span_item_type offered = '0;

   int items_sent = 0;
   int clears_sent = 0;
   int overflows_seen = 0;
   int results_seen = 0;
   int fragments_seen = 0;
   int mismatches = 0;
   int settings_run = 1;
   int burst_left = 4;
   int gap_left = 0;
   int holdoff_left = 0;
   int ready_mode = 0;
   int mode_left = 50;

   solid_span_clip_list uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void rebuild_sentinels();
      for (int i = 0; i < MAX_POSTS; i++) begin
         occ_upper[i] = '0;
         occ_lower[i] = '0;
      end
      occ_upper[0] = ANGLE_MAX;
      occ_lower[0] = HALF_TURN + {1'b0, half_angle};
      occ_upper[1] = HALF_TURN - {1'b0, half_angle};
      occ_lower[1] = '0;
      occ_count = 2;
   endfunction

   function automatic void add_fragment(input int unsigned a, input int unsigned b);
      fragment_type f;
      if (new_fragments.size() < MAX_RESULTS) begin
         f.start = a[ANG_W-1:0];
         f.stop  = b[ANG_W-1:0];
         f.vld   = 1'b1;
         f.ovf   = 1'b0;
         f.last  = 1'b0;
         new_fragments.push_back(f);
      end
   endfunction

   // Clip one span against the list and merge it in; returns 1 when a new post does not fit in the full list.
   function automatic bit merge_span(input int unsigned top, input int unsigned bot);
      int unsigned s, nx, removed;
      s = 0;
      if (occ_count < 2 || occ_count > MAX_POSTS)
         rebuild_sentinels();
      while (s + 1 < occ_count && occ_lower[s] > top + 32'd1)
         s++;
      if (top > occ_upper[s]) begin
         if (bot > occ_upper[s] + 32'd1) begin
            add_fragment(top, bot);
            if (occ_count >= MAX_POSTS)
               return 1'b1;
            for (int unsigned i = occ_count; i > s; i--) begin
               occ_upper[i] = occ_upper[i-1];
               occ_lower[i] = occ_lower[i-1];
            end
            occ_upper[s] = top[ANG_W-1:0];
            occ_lower[s] = bot[ANG_W-1:0];
            occ_count++;
            return 1'b0;
         end
         add_fragment(top, occ_upper[s] + 32'd1);
         occ_upper[s] = top[ANG_W-1:0];
      end
      if (bot >= occ_lower[s])
         return 1'b0;
      nx = s;
      forever begin
         if (nx + 1 >= occ_count || bot > occ_upper[nx+1] + 32'd1) begin
            add_fragment(occ_lower[nx] - 32'd1, bot);
            occ_lower[s] = bot[ANG_W-1:0];
            break;
         end
         add_fragment(occ_lower[nx] - 32'd1, occ_upper[nx+1] + 32'd1);
         nx++;
         if (bot >= occ_lower[nx]) begin
            occ_lower[s] = occ_lower[nx];
            break;
         end
      end
      if (nx == s)
         return 1'b0;
      removed = nx - s;
      for (int unsigned i = nx + 1; i < occ_count; i++) begin
         occ_upper[i-removed] = occ_upper[i];
         occ_lower[i-removed] = occ_lower[i];
      end
      occ_count -= removed;
      return 1'b0;
   endfunction

   function automatic void clip_item(input span_item_type it);
      bit           ovf;
      fragment_type f;
      ovf = 1'b0;
      new_fragments.delete();
      if (it.cmd == CMD_CLEAR)
         rebuild_sentinels();
      else
         ovf = merge_span(it.top, it.bottom);
      if (new_fragments.size() == 0) begin
         f = '0;
         new_fragments.push_back(f);
      end
      if (ovf)
         overflows_seen++;
      foreach (new_fragments[k]) begin
         f      = new_fragments[k];
         f.ovf  = ovf;
         f.last = (k == new_fragments.size() - 1);
         fragments_due.push_back(f);
      end
   endfunction

   function automatic void report_mismatch(input string what, input fragment_type want,
                                           input fragment_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: want start %h stop %h valid %0d ovf %0d last %0d,",
                  $realtime, what, want.start, want.stop, want.vld, want.ovf, want.last);
         $display("   got start %h stop %h valid %0d ovf %0d last %0d",
                  got.start, got.stop, got.vld, got.ovf, got.last);
      end
   endfunction

   // Sender: bursts of items with random gaps; hold an item until it is taken.
   always @(posedge clock) begin : drive_proc
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            clip_item(offered);
            items_sent++;
            if (offered.cmd == CMD_CLEAR)
               clears_sent++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (span_queue.size() != 0) begin
               offered    = span_queue.pop_front();
               next_valid = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  case ($urandom_range(0, 9))
                     0, 1, 2, 3: gap_left = 0;
                     9:          gap_left = $urandom_range(10, 40);
                     default:    gap_left = $urandom_range(1, 4);
                  endcase
               end
            end
         end
         req_tvalid <= next_valid;
         req_tdata  <= {offered.bottom, offered.top};
         req_tuser  <= offered.cmd;
      end
   end

   // Receiver: check each item taken, stall on a shifting pattern, hold off twice.
   always @(posedge clock) begin : watch_proc
      fragment_type got;
      fragment_type want;
      logic         next_ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.start = rsp_tdata[15:0];
            got.stop  = rsp_tdata[31:16];
            got.vld   = rsp_tuser[0];
            got.ovf   = rsp_tuser[1];
            got.last  = rsp_tlast;
            results_seen++;
            if (got.vld)
               fragments_seen++;
            if (fragments_due.size() == 0) begin
               report_mismatch("unexpected item", '0, got);
            end else begin
               want = fragments_due.pop_front();
               if (got !== want)
                  report_mismatch("mismatch", want, got);
            end
            if (results_seen == 60 || results_seen == 300)
               holdoff_left = 400;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            next_ready = 1'b0;
         end else begin
            if (mode_left <= 0) begin
               ready_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(20, 120);
            end
            mode_left--;
            case (ready_mode)
               0:       next_ready = 1'b1;
               1:       next_ready = $urandom_range(0, 1);
               2:       next_ready = ($urandom_range(0, 3) == 0);
               default: next_ready = (mode_left % 5 != 0);
            endcase
         end
         rsp_tready <= next_ready;
      end
   end

   task automatic push_insert(input int top, input int bottom);
      span_item_type it;
      it.cmd    = CMD_INSERT;
      it.top    = top[ANG_W-1:0];
      it.bottom = bottom[ANG_W-1:0];
      span_queue.push_back(it);
   endtask

   task automatic push_clear();
      span_item_type it;
      it.cmd    = CMD_CLEAR;
      it.top    = $urandom;
      it.bottom = $urandom;
      span_queue.push_back(it);
   endtask

   function automatic int pick_angle();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 65535;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   // Mostly well-formed spans around the visible window, with clears and raw noise.
   task automatic push_random(input int n);
      int lo_edge, hi_edge, win, margin, lo, hi, bottom, wmax, top, roll;
      for (int k = 0; k < n; k++) begin
         lo_edge = 32768 - int'(half_angle);
         hi_edge = 32768 + int'(half_angle);
         win     = hi_edge - lo_edge;
         margin  = win / 8 + 16;
         lo      = (lo_edge - margin < 0) ? 0 : lo_edge - margin;
         hi      = (hi_edge + margin > 65535) ? 65535 : hi_edge + margin;
         roll    = $urandom_range(0, 99);
         if (roll < 4) begin
            push_clear();
         end else if (roll < 18) begin
            push_insert(pick_angle(), pick_angle());
         end else begin
            bottom = $urandom_range(hi, lo);
            wmax   = $urandom_range(0, 1) ? win / 32 + 2 : win / 6 + 2;
            top    = bottom + $urandom_range(0, wmax);
            if (top > 65535)
               top = 65535;
            push_insert(top, bottom);
         end
      end
   endtask

   // Hold until every item is sent and answered, then let the sequencer settle.
   task automatic wait_drained();
      @(negedge clock);
      while (span_queue.size() != 0 || req_tvalid || fragments_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_half_angle(input logic [HALF_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      half_angle   = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings_run++;
   endtask

   initial begin
      half_angle = HALF_RESET;
      rebuild_sentinels();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // new post, widen upward, widen downward, fully hidden, bridge everything
      push_insert(16'h9000, 16'h8000);
      push_insert(16'h9800, 16'h9000);
      push_insert(16'h8800, 16'h7000);
      push_insert(16'hF000, 16'hE000);
      push_insert(16'hFFFF, 16'h0000);
      // list has collapsed to one post: next insert rebuilds the sentinels first
      push_insert(16'h8000, 16'h8000);
      push_insert(16'h0000, 16'h9000);
      push_clear();
      // fill the list until a new post no longer fits, then bridge all gaps
      for (int k = 0; k < 15; k++)
         push_insert(16'h6200 + k * 16'h300, 16'h6100 + k * 16'h300);
      push_insert(16'hFFFF, 16'h0000);
      push_random(50);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       write_half_angle(15'd1);
            1:       write_half_angle(15'd32767);
            2:       write_half_angle(15'($urandom_range(2, 32766)));
            default: write_half_angle(15'd16384);
         endcase
         @(negedge clock);
         push_clear();
         push_random(63);
         wait_drained();
      end

      $display("ran %0d items (%0d clears, %0d overflows) under %0d half-angle settings",
               items_sent, clears_sent, overflows_seen, settings_run);
      $display("checked %0d results, %0d of them visible fragments, %0d mismatches",
               results_seen, fragments_seen, mismatches);
      if (mismatches == 0 && fragments_due.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #1500000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/sscl_pkg.sv
src/sscl_post_file.sv
src/solid_span_clip_list.sv
tb/solid_span_clip_list_test.sv
